// ===== src/pra_pkg.sv =====
// Package of the page range allocator: defaults, codes and the sequencer state type.
`timescale 1ns / 1ps
package pra_pkg;

	// Default table depth and page size in bytes.
	localparam int unsigned MAX_RANGES_DEF = 16;
	localparam int unsigned PAGE_BYTES_DEF = 4096;

	// Operation codes.
	localparam logic OP_RESERVE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// Status codes.
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_ZERO = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	// Sequencer states.
	typedef enum logic [4:0] {
		S_IDLE,
		S_PREP,
		S_RV_RD,
		S_RV_CHK,
		S_RV_END,
		S_RL_RD,
		S_RL_MUL,
		S_RL_CHK,
		S_T_MUL,
		S_T_END,
		S_MG_RD,
		S_MG_MUL,
		S_MG_CHK,
		S_DROP_RD,
		S_DROP_WR,
		S_OUT
	} state_t;

endpackage

// ===== src/pra_ifs.sv =====
// Handshake interfaces of the page range allocator: request, response and configuration.
`timescale 1ns / 1ps
interface pra_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [63:0] range_start;
	logic [31:0] page_count;
	modport source (output valid, opcode, range_start, page_count, input ready);
	modport sink   (input valid, opcode, range_start, page_count, output ready);
endinterface

interface pra_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] granted_base;
	logic [1:0]  status;
	modport source (output valid, granted_base, status, input ready);
	modport sink   (input valid, granted_base, status, output ready);
endinterface

interface pra_cfg_if;
	logic        valid;
	logic        ready;
	logic [63:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ===== src/page_range_allocator_core.sv =====
// Page range allocator: free range table in RAM, heap top register and operation sequencer.
`timescale 1ns / 1ps
// One request is taken at a time and gives one response. The free range table sits in two
// RAMs with a single read port, and every table entry visited is read and then checked; a
// release also multiplies out the entry end between the read and the check. A reserve walks
// the free ranges and stops early at an exact fit seen before any other fitting range; when
// a range is used up, the entries behind it are moved down. A release that appends a range
// walks the table once. A release that grows a range walks the table a second time to merge,
// and entries are moved down when two ranges merge; a release that ends at the heap top needs
// no walk, and rejected requests go straight to the response. A new request can be taken
// while the previous response still waits in the output register.
// Writing heap_start loads the heap top; it is meant for an idle block only.
module page_range_allocator_core #(
	parameter int unsigned MAX_RANGES = pra_pkg::MAX_RANGES_DEF,
	parameter int unsigned PAGE_BYTES = pra_pkg::PAGE_BYTES_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	pra_req_if.sink   req,
	pra_rsp_if.source rsp,
	pra_cfg_if.sink   cfg
);
	import pra_pkg::*;

	localparam int unsigned IW = $clog2(MAX_RANGES);
	localparam int unsigned CW = $clog2(MAX_RANGES + 1);

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [63:0]   heap_top_q, heap_top_d;
	logic          out_valid_q;
	logic [63:0]   out_base_q;
	logic [1:0]    out_status_q;

	// Operation registers.
	logic          op_q;
	logic [63:0]   base_q;
	logic [31:0]   pages_q;
	logic [63:0]   span_q;
	logic [63:0]   end_q;
	logic [63:0]   prod_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] j_q;
	logic          have_q;
	logic [IW-1:0] best_q;
	logic [63:0]   best_base_q;
	logic [31:0]   best_pages_q;
	logic [IW-1:0] t_q;
	logic [63:0]   t_base_q;
	logic [31:0]   t_pages_q;
	logic [63:0]   tend_q;
	logic [63:0]   granted_q;
	logic [1:0]    status_q;

	// RAM ports.
	logic          ram_we, ram_re;
	logic [IW-1:0] ram_waddr, ram_raddr;
	logic [63:0]   ram_wbase, rd_base;
	logic [31:0]   ram_wpages, rd_pages;

	pra_ram #(.WIDTH(64), .DEPTH(MAX_RANGES)) u_base_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wbase),
		.re(ram_re), .raddr(ram_raddr), .rdata(rd_base)
	);

	pra_ram #(.WIDTH(32), .DEPTH(MAX_RANGES)) u_pages_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wpages),
		.re(ram_re), .raddr(ram_raddr), .rdata(rd_pages)
	);

	// Shared conditions of the sequencer.
	logic req_acc, req_zero, out_free, k_live, k_is_t, drop_more;
	logic fit, exact, rl_lo, rl_hi, mg_lo, mg_hi, top_hit;
	logic [63:0] rel_end;

	assign req_acc   = req.valid && req.ready;
	assign req_zero  = (req.page_count == 32'd0) ||
		(req.opcode == OP_RELEASE && req.range_start == 64'd0);
	assign out_free  = !out_valid_q || rsp.ready;
	assign k_live    = k_q < count_q;
	assign k_is_t    = k_q == CW'(t_q);
	assign drop_more = (j_q + CW'(1)) < count_q;
	assign fit       = (rd_pages >= pages_q) && (!have_q || best_pages_q < rd_pages);
	assign exact     = rd_pages == pages_q;
	assign rl_lo     = rd_base == end_q;
	assign rl_hi     = (rd_base + prod_q) == base_q;
	assign mg_lo     = rd_base == tend_q;
	assign mg_hi     = (rd_base + prod_q) == t_base_q;
	assign rel_end   = base_q + span_q;
	assign top_hit   = rel_end == heap_top_q;

	assign req.ready        = state_q == S_IDLE;
	assign cfg.ready        = 1'b1;
	assign rsp.valid        = out_valid_q;
	assign rsp.granted_base = out_base_q;
	assign rsp.status       = out_status_q;

	// Next state, table writes and control state updates.
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		heap_top_d = heap_top_q;
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wbase  = '0;
		ram_wpages = '0;
		ram_re     = 1'b0;
		ram_raddr  = k_q[IW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					if (req_zero) begin
						state_d = S_OUT;
					end else if (req.opcode == OP_RESERVE) begin
						state_d = S_RV_RD;
					end else begin
						state_d = S_PREP;
					end
				end
			end
			S_PREP: begin
				if (top_hit) begin
					heap_top_d = base_q;
					state_d    = S_OUT;
				end else begin
					state_d = S_RL_RD;
				end
			end
			S_RV_RD: begin
				if (k_live) begin
					ram_re  = 1'b1;
					state_d = S_RV_CHK;
				end else begin
					state_d = S_RV_END;
				end
			end
			S_RV_CHK: begin
				state_d = (fit && exact) ? S_RV_END : S_RV_RD;
			end
			S_RV_END: begin
				if (!have_q) begin
					heap_top_d = heap_top_q + span_q;
					state_d    = S_OUT;
				end else if (best_pages_q > pages_q) begin
					ram_we     = 1'b1;
					ram_waddr  = best_q;
					ram_wbase  = best_base_q + span_q;
					ram_wpages = best_pages_q - pages_q;
					state_d    = S_OUT;
				end else begin
					state_d = S_DROP_RD;
				end
			end
			S_RL_RD: begin
				if (k_live) begin
					ram_re  = 1'b1;
					state_d = S_RL_MUL;
				end else begin
					if (count_q < CW'(MAX_RANGES)) begin
						ram_we     = 1'b1;
						ram_waddr  = count_q[IW-1:0];
						ram_wbase  = base_q;
						ram_wpages = pages_q;
						count_d    = count_q + CW'(1);
					end
					state_d = S_OUT;
				end
			end
			S_RL_MUL: begin
				state_d = S_RL_CHK;
			end
			S_RL_CHK: begin
				if (rl_lo || rl_hi) begin
					ram_we     = 1'b1;
					ram_waddr  = k_q[IW-1:0];
					ram_wbase  = rl_lo ? base_q : rd_base;
					ram_wpages = rd_pages + pages_q;
					state_d    = S_T_MUL;
				end else begin
					state_d = S_RL_RD;
				end
			end
			S_T_MUL: begin
				state_d = S_T_END;
			end
			S_T_END: begin
				state_d = S_MG_RD;
			end
			S_MG_RD: begin
				if (!k_live) begin
					state_d = S_OUT;
				end else if (!k_is_t) begin
					ram_re  = 1'b1;
					state_d = S_MG_MUL;
				end
			end
			S_MG_MUL: begin
				state_d = S_MG_CHK;
			end
			S_MG_CHK: begin
				if (mg_lo || mg_hi) begin
					ram_we     = 1'b1;
					ram_waddr  = k_q[IW-1:0];
					ram_wbase  = mg_lo ? t_base_q : rd_base;
					ram_wpages = rd_pages + t_pages_q;
					state_d    = S_DROP_RD;
				end else begin
					state_d = S_MG_RD;
				end
			end
			S_DROP_RD: begin
				ram_raddr = IW'(j_q + CW'(1));
				if (drop_more) begin
					ram_re  = 1'b1;
					state_d = S_DROP_WR;
				end else begin
					count_d = count_q - CW'(1);
					state_d = S_OUT;
				end
			end
			S_DROP_WR: begin
				ram_we     = 1'b1;
				ram_waddr  = j_q[IW-1:0];
				ram_wbase  = rd_base;
				ram_wpages = rd_pages;
				state_d    = S_DROP_RD;
			end
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// A configuration write loads the heap top.
		if (cfg.valid) begin
			heap_top_d = cfg.data;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			heap_top_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			heap_top_q <= heap_top_d;
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_base_q   <= granted_q;
			out_status_q <= status_q;
		end
	end

	// Operation datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					op_q      <= req.opcode;
					base_q    <= req.range_start;
					pages_q   <= req.page_count;
					span_q    <= 64'(req.page_count) * 64'(PAGE_BYTES);
					k_q       <= '0;
					have_q    <= 1'b0;
					granted_q <= '0;
					status_q  <= req_zero ? STAT_ZERO : STAT_OK;
				end
			end
			S_PREP: begin
				end_q <= rel_end;
			end
			S_RV_CHK: begin
				if (fit) begin
					best_q       <= k_q[IW-1:0];
					best_base_q  <= rd_base;
					best_pages_q <= rd_pages;
					have_q       <= 1'b1;
				end
				if (!(fit && exact)) begin
					k_q <= k_q + CW'(1);
				end
			end
			S_RV_END: begin
				granted_q <= have_q ? best_base_q : heap_top_q;
				j_q       <= CW'(best_q);
			end
			S_RL_RD: begin
				if (!k_live && count_q >= CW'(MAX_RANGES)) begin
					status_q <= STAT_FULL;
				end
			end
			S_RL_MUL, S_MG_MUL: begin
				prod_q <= 64'(rd_pages) * 64'(PAGE_BYTES);
			end
			S_RL_CHK: begin
				if (rl_lo || rl_hi) begin
					t_q       <= k_q[IW-1:0];
					t_base_q  <= rl_lo ? base_q : rd_base;
					t_pages_q <= rd_pages + pages_q;
				end else begin
					k_q <= k_q + CW'(1);
				end
			end
			S_T_MUL: begin
				prod_q <= 64'(t_pages_q) * 64'(PAGE_BYTES);
			end
			S_T_END: begin
				tend_q <= t_base_q + prod_q;
				k_q    <= '0;
			end
			S_MG_RD: begin
				if (k_live && k_is_t) begin
					k_q <= k_q + CW'(1);
				end
			end
			S_MG_CHK: begin
				if (mg_lo || mg_hi) begin
					j_q <= CW'(t_q);
				end else begin
					k_q <= k_q + CW'(1);
				end
			end
			S_DROP_WR: begin
				j_q <= j_q + CW'(1);
			end
			default: begin
			end
		endcase
	end

	// The table never holds more ranges than it has entries.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(MAX_RANGES))
		else $error("free range count beyond table depth");

	// A dropped release is only reported with a full table.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && status_q == STAT_FULL) |-> count_q == CW'(MAX_RANGES))
		else $error("table full reported with free entries");

	// Errors and releases never hand out an address.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && (status_q != STAT_OK || op_q == OP_RELEASE)) |->
		granted_q == 64'd0)
		else $error("address handed out by release or error");

endmodule

// ===== src/pra_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module pra_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== sim/tb_page_range_allocator_core.sv =====
// Self-checking testbench of the page range allocator core.
`timescale 1ns / 1ps
module tb_page_range_allocator_core;
	import pra_pkg::*;

	localparam int unsigned DEPTH = MAX_RANGES_DEF;
	localparam longint unsigned PG = PAGE_BYTES_DEF;

	// The expected result of one request.
	typedef struct packed {
		logic [63:0] granted_base;
		logic [1:0]  status;
	} grant_t;

	logic clk;
	logic arst_n;

	pra_req_if req ();
	pra_rsp_if rsp ();
	pra_cfg_if cfg ();

	page_range_allocator_core u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cfg   (cfg)
	);

	// Shadow allocator state.
	logic [63:0] shadow_base [DEPTH];
	logic [31:0] shadow_pages[DEPTH];
	int unsigned shadow_count;
	logic [63:0] shadow_top;

	grant_t pending_grants[$];
	int unsigned error_count;
	int unsigned items_sent;
	int unsigned grants_seen;
	int unsigned full_seen;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_cycles;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Timeout guard.
	initial begin
		#200_000_000;
		$display("TIMEOUT at %0t", $time);
		$display("status: fail");
		$finish;
	end

	function automatic logic [63:0] span(input logic [31:0] pages);
		return 64'(pages) * PG;
	endfunction

	function automatic logic [63:0] range_end(input int unsigned k);
		return shadow_base[k] + span(shadow_pages[k]);
	endfunction

	function automatic void drop_shadow_entry(input int unsigned k);
		for (int unsigned j = k; j + 1 < shadow_count; j++) begin
			shadow_base[j]  = shadow_base[j + 1];
			shadow_pages[j] = shadow_pages[j + 1];
		end
		if (shadow_count > 0)
			shadow_count--;
	endfunction

	function automatic logic [63:0] predict_reserve(input logic [31:0] pages);
		int unsigned best;
		bit have;
		logic [63:0] base;
		best = 0;
		have = 0;
		for (int unsigned k = 0; k < shadow_count; k++) begin
			if (shadow_pages[k] >= pages && (!have || shadow_pages[best] < shadow_pages[k])) begin
				best = k;
				have = 1;
				if (shadow_pages[k] == pages)
					break;
			end
		end
		if (have) begin
			base = shadow_base[best];
			if (shadow_pages[best] > pages) begin
				shadow_base[best]  += span(pages);
				shadow_pages[best] -= pages;
			end else begin
				drop_shadow_entry(best);
			end
			return base;
		end
		base = shadow_top;
		shadow_top += span(pages);
		return base;
	endfunction

	function automatic logic [1:0] predict_release(input logic [63:0] base,
			input logic [31:0] pages);
		logic [63:0] stop;
		logic [63:0] t_end;
		int unsigned t;
		bit hit;
		stop = base + span(pages);
		t = 0;
		hit = 0;
		if (stop == shadow_top) begin
			shadow_top = base;
			return STAT_OK;
		end
		for (int unsigned k = 0; k < shadow_count; k++) begin
			if (shadow_base[k] == stop) begin
				shadow_base[k] = base;
				shadow_pages[k] += pages;
				hit = 1;
			end else if (range_end(k) == base) begin
				shadow_pages[k] += pages;
				hit = 1;
			end
			if (hit) begin
				t = k;
				break;
			end
		end
		if (!hit) begin
			if (shadow_count >= DEPTH)
				return STAT_FULL;
			shadow_base[shadow_count]  = base;
			shadow_pages[shadow_count] = pages;
			shadow_count++;
			return STAT_OK;
		end
		t_end = range_end(t);
		for (int unsigned k = 0; k < shadow_count; k++) begin
			if (k == t)
				continue;
			if (shadow_base[k] == t_end) begin
				shadow_base[k] = shadow_base[t];
				shadow_pages[k] += shadow_pages[t];
				drop_shadow_entry(t);
				break;
			end else if (range_end(k) == shadow_base[t]) begin
				shadow_pages[k] += shadow_pages[t];
				drop_shadow_entry(t);
				break;
			end
		end
		return STAT_OK;
	endfunction

	function automatic grant_t predict_grant(input logic op, input logic [63:0] base,
			input logic [31:0] pages);
		grant_t g;
		g.granted_base = '0;
		g.status = STAT_OK;
		if (op == OP_RESERVE) begin
			if (pages == 0)
				g.status = STAT_ZERO;
			else
				g.granted_base = predict_reserve(pages);
		end else begin
			if (base == 0 || pages == 0)
				g.status = STAT_ZERO;
			else
				g.status = predict_release(base, pages);
		end
		return g;
	endfunction

	// Sends one request and records its expected result once accepted. The valid line
	// stays high afterwards so that requests can follow back to back.
	task automatic send_request(input logic op, input logic [63:0] base,
			input logic [31:0] pages);
		grant_t g;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid       <= 1'b1;
		req.opcode      <= op;
		req.range_start <= base;
		req.page_count  <= pages;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		g = predict_grant(op, base, pages);
		pending_grants = {pending_grants, g};
		items_sent++;
		@(negedge clk);
	endtask

	// Waits until every expected result has arrived, then lets the block settle.
	task automatic drain();
		req.valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic write_heap_start(input logic [63:0] value);
		cfg.valid <= 1'b1;
		cfg.data  <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		shadow_top = value;
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Receiver: random stalls, an optional long hold-off, and checking.
	always @(negedge clk) begin
		if (hold_cycles != 0) begin
			rsp.ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			rsp.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		grant_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_grants.size() == 0) begin
				$display("%0t: unexpected transaction base=%h status=%0d", $time,
					rsp.granted_base, rsp.status);
				error_count++;
			end else begin
				want = pending_grants.pop_front();
				grants_seen++;
				if (rsp.status == STAT_FULL)
					full_seen++;
				if (rsp.granted_base !== want.granted_base) begin
					$display("%0t: granted_base expected %h actual %h", $time,
						want.granted_base, rsp.granted_base);
					error_count++;
				end
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, rsp.status);
					error_count++;
				end
			end
		end
	end

	// Random address inside a window near the heap top, page aligned, so ranges meet.
	function automatic logic [63:0] near_address(input logic [63:0] anchor);
		return anchor + 64'(PG) * 64'($urandom_range(40)) - 64'(PG) * 20;
	endfunction

	task automatic test_directed();
		write_heap_start(64'h0000_0000_0010_0000);
		send_request(OP_RESERVE, 64'h0, 32'd0);
		send_request(OP_RELEASE, 64'h0, 32'd4);
		send_request(OP_RELEASE, 64'h1000, 32'd0);
		send_request(OP_RESERVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd4);
		send_request(OP_RESERVE, 64'h0, 32'd2);
		// Release ending at the top lowers it.
		send_request(OP_RELEASE, 64'h0010_4000, 32'd2);
		// Hole below the top, then grow and merge neighbours.
		send_request(OP_RELEASE, 64'h0010_0000, 32'd1);
		send_request(OP_RELEASE, 64'h0010_2000, 32'd1);
		send_request(OP_RELEASE, 64'h0010_1000, 32'd1);
		send_request(OP_RESERVE, 64'h0, 32'd3);
		// Page sum wraps on merge.
		send_request(OP_RELEASE, 64'h0800_0000, 32'hFFFF_FFFF);
		send_request(OP_RELEASE, 64'h0800_0000 - 64'h2000, 32'd2);
		send_request(OP_RESERVE, 64'h0, 32'hFFFF_FFFF);
		send_request(OP_RELEASE, 64'hFFFF_FFFF_FFFF_F000, 32'd1);
		drain();
		// Top at the wrap point: a reserve wraps it past zero, then a release ending at the top lowers it.
		write_heap_start(64'hFFFF_FFFF_FFFF_E000);
		send_request(OP_RESERVE, 64'h0, 32'd4);
		send_request(OP_RELEASE, 64'h1000, 32'd1);
		send_request(OP_RESERVE, 64'h0, 32'd2);
		send_request(OP_RESERVE, 64'h0, 32'd1);
		drain();
	endtask

	task automatic test_table_full();
		write_heap_start(64'h0);
		write_heap_start(64'hFFFF_FFFF_FFFF_FFFF);
		for (int i = 0; i < DEPTH + 4; i++)
			send_request(OP_RELEASE, 64'h1000_0000 + 64'h10_0000 * i, 32'd1);
		drain();
	endtask

	task automatic test_random(input int unsigned count, input logic [63:0] top);
		logic [63:0] base;
		logic [31:0] pages;
		int unsigned pick;
		write_heap_start(top);
		for (int unsigned i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			pages = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(1, 6));
			if (pick < 45) begin
				send_request(OP_RESERVE, {$urandom, $urandom}, pages);
			end else if (pick < 90) begin
				base = near_address(shadow_top);
				send_request(OP_RELEASE, base, pages);
			end else begin
				base = {$urandom, $urandom};
				if ($urandom_range(3) == 0)
					base = 64'h0;
				if ($urandom_range(5) == 0)
					pages = 0;
				send_request(pick[0] ? OP_RELEASE : OP_RESERVE, base, pages);
			end
		end
		drain();
	endtask

	task automatic test_backpressure();
		hold_cycles = 400;
		for (int i = 0; i < 40; i++)
			send_request(i[0] ? OP_RELEASE : OP_RESERVE,
				near_address(shadow_top), 32'($urandom_range(1, 3)));
		drain();
	endtask

	initial begin
		error_count = 0;
		items_sent = 0;
		grants_seen = 0;
		full_seen = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		shadow_count = 0;
		shadow_top = '0;
		req.valid = 1'b0;
		req.opcode = OP_RESERVE;
		req.range_start = '0;
		req.page_count = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_table_full();
		test_random(400, 64'h0000_0040_0000_0000);
		send_idle_pct = 58;
		test_random(400, 64'h8000_0000_0000_0000);
		send_idle_pct = 0;
		recv_stall_pct = 58;
		test_random(400, 64'hFFFF_FFFF_FFF0_0000);
		send_idle_pct = 12;
		recv_stall_pct = 12;
		test_random(300, 64'h0000_0000_0000_1000);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_backpressure();

		$display("Covered %0d requests, %0d results checked, %0d table-full drops,",
			items_sent, grants_seen, full_seen);
		$display("over several heap start values and idle patterns; %0d mismatches.",
			error_count);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
